>>> rtl/pspt_pkg.sv
package pspt_pkg;

    localparam int ADDR_W            = 32;
    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = '1;

    // One memory access as seen on the request channel.
    typedef struct packed {
        logic [ADDR_W-1:0] access_pc;
        logic [ADDR_W-1:0] access_addr;
    } access_t;

    // One prefetch proposal as seen on the response channel.
    typedef struct packed {
        logic              prefetch_valid;
        logic [ADDR_W-1:0] prefetch_addr;
    } prefetch_t;

    // Head of the queue between front and back.
    typedef struct packed {
        logic    valid;
        access_t item;
    } queue_head_t;

    // One table entry as stored in the table memory.
    typedef struct packed {
        logic              learned;
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] last_addr;
        logic [ADDR_W-1:0] pc;
    } entry_t;

endpackage

>>> rtl/pspt_front.sv
module pspt_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  pspt_pkg::access_t     req_data,
    output pspt_pkg::queue_head_t head,
    input  logic                  pop
);
    import pspt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    access_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              do_pop;

    assign req_stall = (count_reg == FULL_CNT);
    assign push      = req_valid && !req_stall;
    assign do_pop    = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Capture the incoming transaction into its queue slot.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= req_data;
        end
    end

endmodule

>>> rtl/pspt_back.sv
module pspt_back #(
    parameter int TABLE_ENTRIES = pspt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pspt_pkg::queue_head_t         head,
    output logic                          pop,
    input  logic [pspt_pkg::ADDR_W-1:0]   address_limit,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output pspt_pkg::prefetch_t           rsp_data
);
    import pspt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    entry_t            table_mem [TABLE_ENTRIES];

    state_t            state_reg, state_next;
    access_t           item_reg;
    logic [CNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              check_vld_reg, check_vld_next;
    logic [IDX_W-1:0]  check_idx_reg, check_idx_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  rptr_reg, rptr_next;
    entry_t            rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    prefetch_t         out_data_reg;

    logic              start;
    logic              match;
    logic              miss;
    logic              done;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_data;
    logic [ADDR_W-1:0] target;
    logic              pf_ok;
    prefetch_t         result;

    // Take a new access only when the output register will be free at completion.
    assign start = (state_reg == ST_IDLE) && head.valid && (!out_valid_reg || !rsp_stall);
    assign pop   = start;

    assign match = (state_reg == ST_SCAN) && check_vld_reg
                   && (rd_data_reg.pc == item_reg.access_pc);
    assign miss  = (state_reg == ST_SCAN) && !check_vld_reg;
    assign done  = match || miss;

    assign rd_en  = (start && (fill_reg != '0))
                    || ((state_reg == ST_SCAN) && !done && (issue_idx_reg < fill_reg));
    assign rd_idx = start ? '0 : issue_idx_reg[IDX_W-1:0];

    assign target = item_reg.access_addr + rd_data_reg.stride;
    assign pf_ok  = match && rd_data_reg.learned && (target != '0) && (target < address_limit);

    always_comb
    begin
        result.prefetch_valid = pf_ok;
        result.prefetch_addr  = pf_ok ? target : '0;
    end

    // Fill on a miss, learn the stride on the first hit; learned entries stay as is.
    always_comb
    begin
        wr_en  = miss || (match && !rd_data_reg.learned);
        wr_idx = miss ? rptr_reg : check_idx_reg;
        if (miss)
        begin
            wr_data.learned   = 1'b0;
            wr_data.stride    = '0;
            wr_data.last_addr = item_reg.access_addr;
            wr_data.pc        = item_reg.access_pc;
        end
        else
        begin
            wr_data.learned   = 1'b1;
            wr_data.stride    = item_reg.access_addr - rd_data_reg.last_addr;
            wr_data.last_addr = item_reg.access_addr;
            wr_data.pc        = rd_data_reg.pc;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        check_vld_next = check_vld_reg;
        check_idx_next = check_idx_reg;
        fill_next      = fill_reg;
        rptr_next      = rptr_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next     = ST_SCAN;
                    check_vld_next = rd_en;
                    check_idx_next = '0;
                    issue_idx_next = CNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                check_vld_next = rd_en;
                check_idx_next = rd_idx;
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                if (done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
                if (miss)
                begin
                    rptr_next = (rptr_reg == LAST_IDX) ? '0 : rptr_reg + 1'b1;
                    if (fill_reg != FULL_CNT)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_idx_reg <= '0;
            check_vld_reg <= 1'b0;
            check_idx_reg <= '0;
            fill_reg      <= '0;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_idx_reg <= issue_idx_next;
            check_vld_reg <= check_vld_next;
            check_idx_reg <= check_idx_next;
            fill_reg      <= fill_next;
            rptr_reg      <= rptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= head.item;
        end
        if (done)
        begin
            out_data_reg <= result;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_idx];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

>>> rtl/pc_stride_prefetch_table.sv
// Channel   Handshake                Payload        Direction
// req       req_valid / req_stall    access_t       in  (one memory access)
// rsp       rsp_valid / rsp_stall    prefetch_t     out (one result per access)
// cfg       cfg_wr_en                cfg_wr_data    in  (address_limit)
//
// Scan: the table engine checks the entries in order from entry 0, up to the first hit
//   or, on a miss, through every filled entry; the scan reads one entry per cycle through
//   the single read port of the table memory.
// Reset: all control state clears at once; entries fill in order and a fill count
//   marks the valid ones, so the table needs no clearing pass.
// Stalls: a two-deep queue holds accesses while the engine scans; the result register
//   holds a stalled response and the engine starts the next access as it drains.
module pc_stride_prefetch_table #(
    parameter int TABLE_ENTRIES = pspt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  pspt_pkg::access_t           req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output pspt_pkg::prefetch_t         rsp_data,
    input  logic                        cfg_wr_en,
    input  logic [pspt_pkg::ADDR_W-1:0] cfg_wr_data
);
    import pspt_pkg::*;

    logic [ADDR_W-1:0] limit_reg;
    queue_head_t       head;
    logic              pop;

    // Hold the prefetch bound; the user must write it only while the block is idle, which is not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Front: accept transactions into the queue.
    pspt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .head      (head),
        .pop       (pop)
    );

    // Back: scan the table, update the entry, issue the result.
    pspt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .address_limit (limit_reg),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data)
    );

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pspt_pkg::*;

    // Table size under test; the predictor table is sized the same way.
    localparam int N_ENTRIES = TABLE_ENTRIES_DEF;

    // Stop adding random accesses once this many have been sent in total.
    localparam int ITEM_TARGET = 1350;

    // Worst case per access: longest request gap, a full table scan on a miss,
    // and the longest response stall. The cap is several times that figure times ITEM_TARGET.
    localparam int CYCLE_LIMIT = 1_200_000;

    // Cycles allowed after the last result for any stray response to show up.
    localparam int TAIL_CYCLES = N_ENTRIES + 20;

    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // DUT-facing signals. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                req_valid   = 1'b0;
    logic                req_stall;
    access_t             req_data    = '0;
    logic                rsp_valid;
    logic                rsp_stall   = 1'b0;
    prefetch_t           rsp_data;
    logic                cfg_wr_en   = 1'b0;
    logic [ADDR_W-1:0]   cfg_wr_data = '0;

    pc_stride_prefetch_table #(
        .TABLE_ENTRIES (N_ENTRIES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Prediction state: a shadow copy of the block's prediction table,
    // the round-robin fill pointer and the address limit register.
    // ------------------------------------------------------------------
    logic              tbl_valid   [N_ENTRIES];
    logic [ADDR_W-1:0] tbl_pc      [N_ENTRIES];
    logic [ADDR_W-1:0] tbl_last    [N_ENTRIES];
    logic [ADDR_W-1:0] tbl_stride  [N_ENTRIES];
    logic              tbl_learned [N_ENTRIES];
    int                fill_ptr;
    logic [ADDR_W-1:0] limit_shadow;

    // Proposals still owed by the block, oldest first.
    prefetch_t proposal_q[$];

    int  items_sent;
    int  mismatch_count;
    int  cycle_count;

    // Idle knobs: when set, the request side inserts gaps and the response
    // side inserts stalls; when clear, that side runs back to back.
    bit  req_gaps_on;
    bit  rsp_stalls_on;

    // Walk the table for one access and return the prefetch that the block
    // must answer with. Update the shadow table the way the hardware does.
    function automatic prefetch_t predict_access(access_t acc);
        prefetch_t         res;
        int                hit_idx;
        logic [ADDR_W-1:0] target;
        res     = '0;
        hit_idx = -1;
        // Lowest-numbered valid match wins; duplicates never occur anyway.
        for (int k = 0; k < N_ENTRIES; k++)
        begin
            if (tbl_valid[k] && tbl_pc[k] == acc.access_pc)
            begin
                hit_idx = k;
                break;
            end
        end
        if (hit_idx < 0)
        begin
            // Miss: claim the slot under the fill pointer, advance it.
            tbl_valid[fill_ptr]   = 1'b1;
            tbl_pc[fill_ptr]      = acc.access_pc;
            tbl_last[fill_ptr]    = acc.access_addr;
            tbl_stride[fill_ptr]  = '0;
            tbl_learned[fill_ptr] = 1'b0;
            fill_ptr              = (fill_ptr + 1) % N_ENTRIES;
        end
        else if (!tbl_learned[hit_idx])
        begin
            // Second sighting of this pc: learn the stride once and for all.
            tbl_stride[hit_idx]  = acc.access_addr - tbl_last[hit_idx];
            tbl_last[hit_idx]    = acc.access_addr;
            tbl_learned[hit_idx] = 1'b1;
        end
        else
        begin
            // Learned entry: propose addr + stride, wrapping at 32 bits.
            target = acc.access_addr + tbl_stride[hit_idx];
            if (target != '0 && target < limit_shadow)
            begin
                res.prefetch_valid = 1'b1;
                res.prefetch_addr  = target;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the cycle watchdog.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, proposal_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Response side: draw a stall length for every transaction, hold stall
    // for that many cycles, then release it and wait for the handshake.
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        forever
        begin
            hold = rsp_stalls_on ? $urandom_range(0, 19) : 0;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every response transaction is compared field by field
    // with the oldest outstanding prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_responses
        prefetch_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
        begin
            if (proposal_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: response with nothing outstanding: valid=%0b addr=%08h",
                             $realtime, rsp_data.prefetch_valid, rsp_data.prefetch_addr);
            end
            else
            begin
                want = proposal_q.pop_front();
                if (rsp_data.prefetch_valid !== want.prefetch_valid ||
                    rsp_data.prefetch_addr  !== want.prefetch_addr)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: prefetch mismatch: expected valid=%0b addr=%08h, %s",
                                 $realtime, want.prefetch_valid, want.prefetch_addr,
                                 $sformatf("got valid=%0b addr=%08h",
                                           rsp_data.prefetch_valid,
                                           rsp_data.prefetch_addr));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks.
    // ------------------------------------------------------------------

    // Send one access transaction. Hold valid and payload until accepted and
    // leave valid high afterwards, so a back-to-back follower never drops it
    // and raises it in the same step. Record the prediction at acceptance.
    task automatic send_access(input logic [ADDR_W-1:0] pc, input logic [ADDR_W-1:0] addr);
        int      gap;
        access_t acc;
        acc.access_pc   = pc;
        acc.access_addr = addr;
        gap = req_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= acc;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        proposal_q.push_back(predict_access(acc));
        items_sent++;
    endtask

    // Drop valid and wait until every outstanding result has come back.
    // Always wait for a clock edge first so valid never toggles twice in a step.
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (proposal_q.size() != 0);
    endtask

    // Write address_limit while the block is idle.
    task automatic program_address_limit(input logic [ADDR_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_shadow = value;
    endtask

    // Pick idle behavior for the next stretch; mostly on, sometimes off.
    task automatic pick_idle_mode();
        req_gaps_on   = ($urandom_range(0, 2) != 0);
        rsp_stalls_on = ($urandom_range(0, 2) != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Miss, learning hit and proposing hit, plus the proposal corner cases
    // under the reset value of the limit.
    task automatic test_basic_operations();
        pick_idle_mode();
        // Miss, learn stride 0x40, then propose from a distant address.
        send_access(32'h0000_0000, 32'h0000_1000);
        send_access(32'h0000_0000, 32'h0000_1040);
        send_access(32'h0000_0000, 32'h0000_2000);
        // Negative stride whose proposal lands on zero: drop it.
        send_access(32'hFFFF_FFFF, 32'h0000_0100);
        send_access(32'hFFFF_FFFF, 32'h0000_0000);
        send_access(32'hFFFF_FFFF, 32'h0000_0100);
        // Proposal that wraps past the top of the address space.
        send_access(32'h8000_0000, 32'hFFFF_FFF0);
        send_access(32'h8000_0000, 32'hFFFF_FFF8);
        send_access(32'h8000_0000, 32'hFFFF_FFFF);
        // Proposal equal to the reset limit is dropped, one below passes.
        send_access(32'h1234_5678, 32'h0000_0000);
        send_access(32'h1234_5678, 32'h0000_0010);
        send_access(32'h1234_5678, 32'hFFFF_FFEF);
        send_access(32'h1234_5678, 32'hFFFF_FFEE);
        // Stride stays fixed: a later hit with a new address keeps +0x40.
        send_access(32'h0000_0000, 32'h0000_5000);
        // Zero stride proposes the access address itself.
        send_access(32'h5555_AAAA, 32'hAAAA_5555);
        send_access(32'h5555_AAAA, 32'hAAAA_5555);
        send_access(32'h5555_AAAA, 32'hAAAA_5555);
        drain_results();
    endtask

    // Proposals at, below and above the limit, and the limit extremes.
    task automatic test_address_limit();
        pick_idle_mode();
        send_access(32'hCAFE_0000, 32'h0FFF_FF00);
        send_access(32'hCAFE_0000, 32'h0FFF_FF10);
        program_address_limit(32'h1000_0000);
        send_access(32'hCAFE_0000, 32'h0FFF_FFEF);
        send_access(32'hCAFE_0000, 32'h0FFF_FFF0);
        send_access(32'hCAFE_0000, 32'h0FFF_FFF1);
        // Limit zero and one: nothing can ever be proposed.
        program_address_limit(32'h0000_0000);
        send_access(32'hCAFE_0000, 32'h0000_0010);
        program_address_limit(32'h0000_0001);
        send_access(32'hCAFE_0000, 32'h0000_0010);
        send_access(32'hCAFE_0000, 32'hFFFF_FFF0);
        program_address_limit(32'hFFFF_FFFE);
        send_access(32'hCAFE_0000, 32'hFFFF_FFED);
        send_access(32'hCAFE_0000, 32'hFFFF_FFEE);
        program_address_limit(LIMIT_RESET);
        send_access(32'hCAFE_0000, 32'hFFFF_FFEE);
    endtask

    // Overfill the table so the fill pointer wraps and evicts old entries,
    // then revisit evicted and surviving pcs. The surviving pcs revisited sit in
    // the low slots after the wrap, so their hits end the scan early.
    task automatic test_table_wraparound();
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] base;
        pick_idle_mode();
        for (int i = 0; i < N_ENTRIES + 12; i++)
            send_access(32'hA000_0000 + i * 4, 32'h0100_0000 + i * 32'h40);
        for (int i = 0; i < 10; i++)
            send_access(32'hA000_0000 + i * 4, 32'h0200_0000 + i * 32'h40);
        for (int i = N_ENTRIES + 11; i >= N_ENTRIES + 2; i--)
        begin
            pc   = 32'hA000_0000 + i * 4;
            base = 32'h0100_0000 + i * 32'h40;
            send_access(pc, base + 32'h1000);
            send_access(pc, base + 32'h2000);
        end
        drain_results();
    endtask

    // Bursts of strided streams from a pool of pcs with random content, laced
    // with broken sequences and stray accesses. The pool partly survives
    // from burst to burst, and some bursts draw from a pool larger than the table.
    task automatic test_random_streams();
        logic [ADDR_W-1:0] pool_pc     [160];
        logic [ADDR_W-1:0] pool_next   [160];
        logic [ADDR_W-1:0] pool_stride [160];
        logic [ADDR_W-1:0] new_limit;
        int                pool_size;
        int                burst_len;
        int                idx;
        int                pick;
        for (int i = 0; i < 160; i++)
        begin
            pool_pc[i]     = $urandom();
            pool_next[i]   = $urandom();
            pool_stride[i] = $urandom_range(1, 16) * 8;
        end
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0: pool_size = $urandom_range(1, 4);
                1: pool_size = $urandom_range(5, 12);
                2: pool_size = $urandom_range(13, 48);
                default: pool_size = $urandom_range(100, 160);
            endcase
            // Refresh about half the pool at random; kept slots continue their old stream.
            for (int i = 0; i < pool_size; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    pool_pc[i]   = $urandom();
                    pool_next[i] = $urandom();
                    case ($urandom_range(0, 3))
                        0: pool_stride[i] = $urandom_range(1, 16) * 8;
                        1: pool_stride[i] = 32'h0 - $urandom_range(1, 16) * 64;
                        2: pool_stride[i] = $urandom();
                        default: pool_stride[i] = '0;
                    endcase
                end
            end
            // Change the limit now and then, often right across a stream.
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: new_limit = LIMIT_RESET;
                    1: new_limit = $urandom_range(0, 1);
                    2: new_limit = $urandom();
                    3: new_limit = 32'h8000_0000;
                    default: new_limit = pool_next[0] + pool_stride[0] * $urandom_range(2, 6);
                endcase
                program_address_limit(new_limit);
            end
            pick_idle_mode();
            burst_len = $urandom_range(40, 120);
            for (int n = 0; n < burst_len && items_sent < ITEM_TARGET; n++)
            begin
                idx  = $urandom_range(0, pool_size - 1);
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    // Well-formed: next address of this pc's stream.
                    send_access(pool_pc[idx], pool_next[idx]);
                    pool_next[idx] = pool_next[idx] + pool_stride[idx];
                end
                else if (pick < 90)
                    send_access(pool_pc[idx], $urandom());
                else
                    send_access($urandom(), $urandom());
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests in turn, then let the pipeline
    // settle and report.
    // ------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < N_ENTRIES; k++)
            tbl_valid[k] = 1'b0;
        fill_ptr       = 0;
        limit_shadow   = LIMIT_RESET;
        items_sent     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        req_gaps_on    = 1'b1;
        rsp_stalls_on  = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_operations();
        test_address_limit();
        test_table_wraparound();
        test_random_streams();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && proposal_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> pc_stride_prefetch_table.f
rtl/pspt_pkg.sv
rtl/pspt_front.sv
rtl/pspt_back.sv
rtl/pc_stride_prefetch_table.sv
bench/tb_top.sv
